/* design/phfb_pkg.sv */
package phfb_pkg;

   localparam int FREQ_W      = 16;
   localparam int VALUE_W     = 16;
   localparam int SEL_W       = 9;
   localparam int INDEX_W     = 9;
   localparam int ROW_W       = 12;
   localparam int SCALE_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

   localparam logic signed [VALUE_W-1:0] BIN_RESET_VALUE = 16'sh8000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_FREQUENCY = 3'd0,
      CSR_MAX_FREQUENCY = 3'd1,
      CSR_BIN_SCALE     = 3'd2,
      CSR_MIN_VALUE     = 3'd3,
      CSR_MAX_VALUE     = 3'd4,
      CSR_VALUE_SCALE   = 3'd5,
      CSR_PLOT_BOTTOM   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        [FREQ_W-1:0]  min_frequency;
      logic        [FREQ_W-1:0]  max_frequency;
      logic        [SCALE_W-1:0] bin_scale;
      logic signed [VALUE_W-1:0] min_value;
      logic signed [VALUE_W-1:0] max_value;
      logic        [SCALE_W-1:0] value_scale;
      logic        [ROW_W-1:0]   plot_bottom;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      min_frequency: 16'd0,
      max_frequency: 16'd65535,
      bin_scale:     32'd524288,
      min_value:     16'sh8000,
      max_value:     16'sh7fff,
      value_scale:   32'd200,
      plot_bottom:   12'd340
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_READ,
      ST_MODIFY,
      ST_ROW,
      ST_DONE
   } state_type;

endpackage

/* design/phfb_bin_ram.sv */
module phfb_bin_ram
   import phfb_pkg::*;
#(
   parameter int BIN_COUNT = 512,
   parameter int IW        = $clog2(BIN_COUNT)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic        [IW-1:0]      rd_addr,
   output logic signed [VALUE_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic        [IW-1:0]      wr_addr,
   input  logic signed [VALUE_W-1:0] wr_data,
   output logic                      ready
);

   logic signed [VALUE_W-1:0] mem [BIN_COUNT];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      clr_busy_ff;
   logic        [IW-1:0]      clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == IW'(BIN_COUNT - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= BIN_RESET_VALUE;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_busy_ff;

endmodule

/* design/phfb_bin_map.sv */
module phfb_bin_map
   import phfb_pkg::*;
#(
   parameter int BIN_COUNT = 512,
   parameter int IW        = $clog2(BIN_COUNT)
) (
   input  logic                      clock,
   input  logic                      load,
   input  cfg_type                   cfg,
   input  logic        [FREQ_W-1:0]  frequency,
   input  logic signed [VALUE_W-1:0] value,
   output logic                      out_of_range,
   output logic        [IW-1:0]      bin_index
);

   localparam int PROD_W = FREQ_W + SCALE_W;
   localparam int BIN_W  = PROD_W - 15;

   logic [FREQ_W-1:0] diff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] prod_ff;
   logic              oor_in;
   logic              oor_ff;
   logic [PROD_W:0]   rounded;
   logic [BIN_W-1:0]  bin_raw;

   always_comb begin
      diff    = frequency - cfg.min_frequency;
      prod_in = PROD_W'(diff) * PROD_W'(cfg.bin_scale);
      oor_in  = (frequency < cfg.min_frequency) || (frequency > cfg.max_frequency) ||
                (value < cfg.min_value) || (value > cfg.max_value);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         oor_ff  <= oor_in;
      end
   end

   always_comb begin
      rounded = {1'b0, prod_ff} + (PROD_W + 1)'(32768);
      bin_raw = rounded[PROD_W:16];
      if (bin_raw >= BIN_W'(BIN_COUNT)) begin
         bin_index = IW'(BIN_COUNT - 1);
      end else begin
         bin_index = IW'(bin_raw);
      end
   end

   assign out_of_range = oor_ff;

endmodule

/* design/phfb_row_calc.sv */
module phfb_row_calc
   import phfb_pkg::*;
(
   input  logic                      clock,
   input  logic                      load,
   input  cfg_type                   cfg,
   input  logic signed [VALUE_W-1:0] bin_value,
   output logic        [ROW_W-1:0]   plot_y
);

   localparam int OFF_W  = VALUE_W + 1;
   localparam int PROD_W = OFF_W + SCALE_W + 1;
   localparam int RND_W  = PROD_W - 16;
   localparam int Y_W    = RND_W + 2;

   logic signed [OFF_W-1:0]  off;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] sum;
   logic signed [RND_W-1:0]  rnd;
   logic signed [Y_W-1:0]    y;

   always_comb begin
      off     = OFF_W'(bin_value) - OFF_W'(cfg.min_value);
      prod_in = PROD_W'(off) * $signed({(PROD_W - SCALE_W)'(0), cfg.value_scale});
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      sum = prod_ff + PROD_W'(32768);
      rnd = RND_W'(sum >>> 16);
      y   = $signed({(Y_W - ROW_W)'(0), cfg.plot_bottom}) - Y_W'(rnd);
      if (y < 0) begin
         plot_y = '0;
      end else if (y > Y_W'(4095)) begin
         plot_y = '1;
      end else begin
         plot_y = y[ROW_W-1:0];
      end
   end

endmodule

/* design/peak_hold_frequency_binner.sv */
// Peak-hold frequency binner.
// Input stream (req_): one word per point or query. req_tuser is the mode, 0 adds the
// point (frequency, value) to its bin, 1 reads the bin named by bin_select.
// Output stream (rsp_): one word per input word, in order: bin index, stored peak
// value after the update and its display row; rsp_tuser flags an add rejected by the
// frequency or value limits, with all data fields zero.
// Configuration: csr_wr_en with csr_index and csr_wdata writes one limit or scale;
// write only while no word is in flight.
// Sequencing: one word is processed at a time; the bin read-modify-write sequencer
// steps through map multiply, memory read, compare and write back, row multiply,
// output load and return to idle, and a new word is accepted only once it is back
// in idle. A rejected add skips the compare and row steps and goes from the memory
// read straight to output load.
// Reset: limits return to defaults and a clearing pass writes every bin to the lowest
// value, one bin per cycle; req_tready stays low until it ends.
// Stall: a response is held in the output register until taken; the next word may be
// accepted meanwhile and waits in its last step until the output register frees.
module peak_hold_frequency_binner
   import phfb_pkg::*;
#(
   parameter int BIN_COUNT = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // frequency[15:0], value[31:16], bin_select[40:32], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // mode
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // bin_index[8:0], bin_value[24:9], plot_y[36:25], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // out_of_range
   output logic                   rsp_tuser,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IW = $clog2(BIN_COUNT);

   cfg_type cfg_ff, cfg_in;
   state_type state_ff, state_in;

   logic                      mode_ff;
   logic        [FREQ_W-1:0]  freq_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic        [SEL_W-1:0]   sel_ff;
   logic        [IW-1:0]      idx_ff, idx_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      oor_ff, oor_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                      rsp_user_ff, rsp_user_in;

   logic                      accept;
   logic                      map_load;
   logic                      map_oor;
   logic        [IW-1:0]      map_idx;
   logic        [IW-1:0]      sel_idx;
   logic                      ram_ready;
   logic                      rd_en;
   logic signed [VALUE_W-1:0] rd_data;
   logic                      wr_en;
   logic                      row_load;
   logic        [ROW_W-1:0]   plot_y;
   logic                      rsp_load;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_FREQUENCY: cfg_in.min_frequency = csr_wdata[FREQ_W-1:0];
            CSR_MAX_FREQUENCY: cfg_in.max_frequency = csr_wdata[FREQ_W-1:0];
            CSR_BIN_SCALE:     cfg_in.bin_scale     = csr_wdata[SCALE_W-1:0];
            CSR_MIN_VALUE:     cfg_in.min_value     = $signed(csr_wdata[VALUE_W-1:0]);
            CSR_MAX_VALUE:     cfg_in.max_value     = $signed(csr_wdata[VALUE_W-1:0]);
            CSR_VALUE_SCALE:   cfg_in.value_scale   = csr_wdata[SCALE_W-1:0];
            CSR_PLOT_BOTTOM:   cfg_in.plot_bottom   = csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && ram_ready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_tuser;
         freq_ff  <= req_tdata[15:0];
         value_ff <= $signed(req_tdata[31:16]);
         sel_ff   <= req_tdata[40:32];
      end
   end

   always_comb begin
      if (32'(sel_ff) >= BIN_COUNT) begin
         sel_idx = IW'(BIN_COUNT - 1);
      end else begin
         sel_idx = IW'(sel_ff);
      end
   end

   phfb_bin_map #(.BIN_COUNT(BIN_COUNT), .IW(IW)) u_map (
      .clock        (clock),
      .load         (map_load),
      .cfg          (cfg_ff),
      .frequency    (freq_ff),
      .value        (value_ff),
      .out_of_range (map_oor),
      .bin_index    (map_idx)
   );

   phfb_bin_ram #(.BIN_COUNT(BIN_COUNT), .IW(IW)) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (idx_in),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (value_ff),
      .ready   (ram_ready)
   );

   phfb_row_calc u_row (
      .clock     (clock),
      .load      (row_load),
      .cfg       (cfg_ff),
      .bin_value (val_ff),
      .plot_y    (plot_y)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      oor_in       = oor_ff;
      map_load     = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      row_load     = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            map_load = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            idx_in = mode_ff ? sel_idx : map_idx;
            oor_in = !mode_ff && map_oor;
            rd_en  = 1'b1;
            if (!mode_ff && map_oor) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            if (!mode_ff && (value_ff > rd_data)) begin
               wr_en  = 1'b1;
               val_in = value_ff;
            end else begin
               val_in = rd_data;
            end
            state_in = ST_ROW;
         end
         ST_ROW: begin
            row_load = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = oor_ff;
               if (oor_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = {3'b000, plot_y, val_ff, INDEX_W'(idx_ff)};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      oor_ff      <= oor_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* design/phfb_checker.sv */
module phfb_checker
   import phfb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("ready or valid high right after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word accepted while one is in flight");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rejected word carries nonzero data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

endmodule

bind peak_hold_frequency_binner phfb_checker u_phfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
